### sv/sik_pkg.sv
`timescale 1ns / 1ps
package sik_pkg;
  localparam int SLOTS = 4;
  localparam int CORDIC_DEF = 16;
  localparam int ATAN_LEN = 24;
  localparam int WX_W = 20;
  localparam int ZW = 34;
  localparam int CX_W = 36;
  localparam logic [17:0] SPEED_MAX = 18'h3FFFF;

  // register indexes
  localparam logic [2:0] REG_POS0 = 3'd0;
  localparam logic [2:0] REG_DEAD = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_SUM, ST_SQ, ST_SQRT, ST_ROT, ST_CORD, ST_OUT
  } sik_state_t;

  function automatic logic [ZW-1:0] atan_val(input logic [4:0] i);
    logic [ZW-1:0] v;
    unique case (i)
      5'd0: v = 34'd536870912; 5'd1: v = 34'd316933406; 5'd2: v = 34'd167458907;
      5'd3: v = 34'd85004756;  5'd4: v = 34'd42667331;  5'd5: v = 34'd21354465;
      5'd6: v = 34'd10679838;  5'd7: v = 34'd5340245;   5'd8: v = 34'd2670163;
      5'd9: v = 34'd1335087;   5'd10: v = 34'd667544;   5'd11: v = 34'd333772;
      5'd12: v = 34'd166886;   5'd13: v = 34'd83443;    5'd14: v = 34'd41722;
      5'd15: v = 34'd20861;    5'd16: v = 34'd10430;    5'd17: v = 34'd5215;
      5'd18: v = 34'd2608;     5'd19: v = 34'd1304;     5'd20: v = 34'd652;
      5'd21: v = 34'd326;      5'd22: v = 34'd163;      5'd23: v = 34'd81;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

### sv/sik_sqrt.sv
`timescale 1ns / 1ps
// Bit-serial integer square root: two radicand bits per cycle.
module sik_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [41:0] radicand,
  output logic        done,
  output logic [20:0] root
);
  logic [41:0] rad_r, rad_nxt;
  logic [22:0] rem_r, rem_nxt;
  logic [20:0] root_r, root_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [22:0] trial;
  logic [22:0] shifted;

  always_comb begin
    shifted  = {rem_r[20:0], rad_r[41:40]};
    trial    = {root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done     = 1'b0;
    if (start) begin
      rad_nxt = radicand; rem_nxt = '0; root_nxt = '0;
      cnt_nxt = 5'd21; busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[39:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt  = shifted - trial;
        root_nxt = {root_r[19:0], 1'b1};
      end else begin
        rem_nxt  = shifted;
        root_nxt = {root_r[19:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rad_r <= rad_nxt; rem_r <= rem_nxt; root_r <= root_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
  end

  assign root = root_nxt;
endmodule

### sv/swerve_inverse_kinematics_top.sv
`timescale 1ns / 1ps
// Four-wheel swerve inverse kinematics. Each input item (vel_x, vel_y, yaw_rate)
// yields one result item per wheel, in wheel order, tlast on the final wheel.
// Per wheel: yaw multiplies, squares and square root start, bit-serial square root
// (two bits a cycle), then a quadrant pre-rotation and iterative CORDIC when the
// speed exceeds the dead zone (else the wheel's last angle is held), then one output
// handoff, which waits out any output stalls. The sqrt and the CORDIC loop set the
// rate. One item is worked on at a time.
module swerve_inverse_kinematics_top #(
  parameter int WHEEL_COUNT  = sik_pkg::SLOTS,
  parameter int CORDIC_STEPS = sik_pkg::CORDIC_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // vel_x, vel_y, yaw_rate
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // wheel_index[1:0], steer_angle[17:2], wheel_speed[35:18]
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import sik_pkg::*;

  localparam int NW = (WHEEL_COUNT > SLOTS) ? SLOTS : ((WHEEL_COUNT < 1) ? 1 : WHEEL_COUNT);
  localparam int NS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN
                    : ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);

  // configuration
  logic [31:0] pos_r [SLOTS];
  logic [17:0] dz_r;
  logic [15:0] held_r [SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SLOTS; k++) pos_r[k] <= '0;
      dz_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index < REG_DEAD) pos_r[cfg_index[1:0]] <= cfg_wdata;
      else if (cfg_index == REG_DEAD) dz_r <= cfg_wdata[17:0];
    end
  end

  sik_state_t state_r, state_nxt;
  logic [15:0] vx_r, vy_r, om_r;
  logic [1:0]  wh_r;
  logic signed [31:0] mx_r, my_r;
  logic signed [WX_W-1:0] wx_r, wy_r;
  logic [41:0] sq_r;
  logic [17:0] spd_r;
  logic signed [CX_W-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] z_r;
  logic [4:0] it_r;
  logic [39:0] otd_r;
  logic otl_r;

  logic sq_start, sq_done;
  logic [20:0] root;

  sik_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_r),
                   .done(sq_done), .root(root));

  logic signed [15:0] px, py;
  logic signed [WX_W-1:0] wx_c, wy_c;
  logic signed [2*WX_W-1:0] wx_sq, wy_sq;
  logic signed [CX_W-1:0] dx, dy;
  logic signed [ZW-1:0] zr;
  logic [17:0] spd_c;

  assign px = pos_r[wh_r][31:16];
  assign py = pos_r[wh_r][15:0];
  assign wx_c = WX_W'($signed(vx_r)) - WX_W'((mx_r + 32'sd4096) >>> 13);
  assign wy_c = WX_W'($signed(vy_r)) + WX_W'((my_r + 32'sd4096) >>> 13);
  assign wx_sq = wx_c * wx_c;
  assign wy_sq = wy_c * wy_c;
  assign dx = cy_r >>> it_r;
  assign dy = cx_r >>> it_r;
  assign zr = (z_r + ZW'(32768)) >>> 16;
  assign spd_c = (root > 21'(SPEED_MAX)) ? SPEED_MAX : root[17:0];

  always_comb begin
    state_nxt = state_r;
    sq_start  = 1'b0;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_SQ;
      ST_SQ: begin sq_start = 1'b1; state_nxt = ST_SQRT; end
      ST_SQRT: if (sq_done) state_nxt = (spd_c > dz_r) ? ST_ROT : ST_OUT;
      ST_ROT:  state_nxt = ST_CORD;
      ST_CORD: if (it_r == 5'(NS - 1)) state_nxt = ST_OUT;
      ST_OUT: if (!out_tvalid || out_tready) begin
        state_nxt = (wh_r == 2'(NW - 1)) ? ST_IDLE : ST_MUL;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        vx_r <= in_tdata[15:0]; vy_r <= in_tdata[31:16]; om_r <= in_tdata[47:32];
        wh_r <= '0;
      end
      ST_MUL: begin
        mx_r <= $signed(om_r) * py;
        my_r <= $signed(om_r) * px;
      end
      ST_SUM: begin
        wx_r <= wx_c; wy_r <= wy_c;
        sq_r <= 42'(wx_sq) + 42'(wy_sq);
      end
      ST_SQRT: begin
        spd_r <= spd_c; it_r <= '0;
      end
      ST_ROT: begin
        if (wx_r < 0) begin
          if (wy_r >= 0) begin
            cx_r <= CX_W'(wy_r) <<< 12; cy_r <= -(CX_W'(wx_r) <<< 12);
            z_r <= ZW'(1073741824);
          end else begin
            cx_r <= -(CX_W'(wy_r) <<< 12); cy_r <= CX_W'(wx_r) <<< 12;
            z_r <= -ZW'(1073741824);
          end
        end else begin
          cx_r <= CX_W'(wx_r) <<< 12; cy_r <= CX_W'(wy_r) <<< 12; z_r <= '0;
        end
      end
      ST_CORD: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + dx; cy_r <= cy_r - dy; z_r <= z_r + atan_val(it_r);
        end else begin
          cx_r <= cx_r - dx; cy_r <= cy_r + dy; z_r <= z_r - atan_val(it_r);
        end
        // 31 marks a fresh angle for the output stage
        if (it_r == 5'(NS - 1)) it_r <= 5'd31;
        else it_r <= it_r + 5'd1;
      end
      ST_OUT: if (!out_tvalid || out_tready) begin
        otd_r <= {4'd0, spd_r, (it_r == 5'd31) ? zr[15:0] : held_r[wh_r], wh_r};
        otl_r <= (wh_r == 2'(NW - 1));
        wh_r  <= wh_r + 2'd1;
      end
      default: ;
    endcase
  end

  // state, held angles, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_tvalid <= 1'b0;
      for (int k = 0; k < SLOTS; k++) held_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && (!out_tvalid || out_tready)) begin
        out_tvalid <= 1'b1;
        if (it_r == 5'd31) held_r[wh_r] <= zr[15:0];
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  assign out_tdata = otd_r;
  assign out_tlast = otl_r;
endmodule

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import sik_pkg::*;

  localparam int WHEELS = 4;
  localparam int STEPS = 16;
  localparam int IDLE_LIMIT = 20000;

  // index with no register behind it
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic [1:0]  wheel;
    logic [15:0] angle;
    logic [17:0] speed;
    logic        last;
  } wheel_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;

  swerve_inverse_kinematics_top #(.WHEEL_COUNT(WHEELS), .CORDIC_STEPS(STEPS)) dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Kinematics predictor plus queue of expected wheel commands
  class wheel_cmd_board;
    logic [31:0] pos[WHEELS];
    logic [17:0] dead;
    logic [15:0] held[WHEELS];
    wheel_cmd_t pending[$];

    function new();
      foreach (pos[k]) begin
        pos[k] = '0;
        held[k] = '0;
      end
      dead = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      if (idx < REG_DEAD) pos[idx[1:0]] = val;
      else if (idx == REG_DEAD) dead = val[17:0];
    endfunction

    // floor shift right for signed values
    function longint asr(longint v, int s);
      return v >>> s;
    endfunction

    function longint root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic [15:0] heading(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      x = x * 4096;
      y = y * 4096;
      // pre-rotate left half plane by a quarter turn
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = 1073741824;
        end else begin
          t = x; x = -y; y = t; z = -1073741824;
        end
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = asr(y, i);
        dy = asr(x, i);
        if (y > 0) begin
          x += dx; y -= dy; z += longint'(atan_val(i[4:0]));
        end else begin
          x -= dx; y += dy; z -= longint'(atan_val(i[4:0]));
        end
      end
      t = asr(z + 32768, 16);
      return t[15:0];
    endfunction

    function void note_command(logic [47:0] d);
      longint vx, vy, om, px, py, wx, wy, spd;
      wheel_cmd_t c;
      vx = longint'($signed(d[15:0]));
      vy = longint'($signed(d[31:16]));
      om = longint'($signed(d[47:32]));
      for (int k = 0; k < WHEELS; k++) begin
        px = longint'($signed(pos[k][31:16]));
        py = longint'($signed(pos[k][15:0]));
        wx = vx - asr(om * py + 4096, 13);
        wy = vy + asr(om * px + 4096, 13);
        spd = root(wx * wx + wy * wy);
        if (spd > 262143) spd = 262143;
        if (spd > longint'(dead)) held[k] = heading(wy, wx);
        c.wheel = k[1:0];
        c.angle = held[k];
        c.speed = spd[17:0];
        c.last = (k == WHEELS - 1);
        pending.push_back(c);
      end
    endfunction

    task check_command(logic [39:0] d, logic lst);
      wheel_cmd_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected wheel command", d[1:0], -1);
        return;
      end
      w = pending.pop_front();
      if (d[1:0] != w.wheel) report_mismatch("wheel_index", d[1:0], w.wheel);
      if (d[17:2] != w.angle)
        report_mismatch("steer_angle", $signed(d[17:2]), $signed(w.angle));
      if (d[35:18] != w.speed) report_mismatch("wheel_speed", d[35:18], w.speed);
      if (lst != w.last) report_mismatch("last_of_run", lst, w.last);
    endtask
  endclass

  wheel_cmd_board board = new();

  // result side: random stalls, check on handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_command(out_tdata, out_tlast);
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("swerve_inverse_kinematics_top: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    board.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays up after the handshake until the next item or an idle cycle
  task automatic send_command(input logic [15:0] vx, input logic [15:0] vy,
                              input logic [15:0] om);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {om, vy, vx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_command({om, vy, vx});
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_geometry(input bit extreme);
    for (int k = 0; k < WHEELS; k++) begin
      if (extreme) write_reg(REG_POS0 + k[2:0], $urandom_range(1) ? 32'h7FFF_8000 : 32'h8000_7FFF);
      else write_reg(REG_POS0 + k[2:0], $urandom());
    end
  endtask

  task automatic random_command();
    logic [15:0] vx, vy, om;
    vx = $urandom();
    vy = $urandom();
    om = $urandom();
    // a quarter of the commands get moderate speeds so the dead zone and holding both show up
    if ($urandom_range(3) == 0) begin
      vx = $signed(vx) >>> $urandom_range(15);
      vy = $signed(vy) >>> $urandom_range(15);
      om = $signed(om) >>> $urandom_range(15);
    end
    send_command(vx, vy, om);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: typical square footprint, zero dead zone
    write_reg(REG_POS0, {16'sd2048, 16'sd2048});
    write_reg(REG_POS0 + 3'd1, {-16'sd2048, 16'sd2048});
    write_reg(REG_POS0 + 3'd2, {-16'sd2048, -16'sd2048});
    write_reg(REG_POS0 + 3'd3, {16'sd2048, -16'sd2048});
    write_reg(REG_DEAD, 32'd0);
    send_command(16'd0, 16'd0, 16'd0);        // standstill: held angle
    send_command(16'd1024, 16'd0, 16'd0);
    send_command(-16'sd1024, 16'd0, 16'd0);   // pi
    send_command(-16'sd1024, -16'sd1, 16'd0); // just above -pi
    send_command(16'd0, 16'd1024, 16'd0);
    send_command(16'd0, -16'sd1024, 16'd0);
    send_command(16'd0, 16'd0, 16'd2048);     // pure spin
    send_command(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_command(16'h8000, 16'h8000, 16'h8000);
    send_command(16'h7FFF, 16'h8000, 16'h0000);
    send_command(16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();
    // extreme geometry for large wheel speeds
    write_reg(REG_POS0, 32'h7FFF_7FFF);
    write_reg(REG_POS0 + 3'd1, 32'h8000_8000);
    write_reg(REG_POS0 + 3'd2, 32'h7FFF_8000);
    write_reg(REG_POS0 + 3'd3, 32'h8000_7FFF);
    write_reg(REG_DEAD, 32'h3FFFF);           // everything held
    send_command(16'h7FFF, 16'h8000, 16'h8000);
    send_command(16'h8000, 16'h7FFF, 16'h7FFF);
    drain();
    write_reg(REG_DEAD, 32'd500);
    send_command(16'd300, 16'd300, 16'd0);    // below dead zone
    send_command(16'd400, 16'd300, 16'd0);    // exactly at it
    send_command(16'd401, 16'd300, 16'd0);    // root rounds down to 500: still at it
    drain();
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);

    // random phases across idling patterns and settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      random_geometry(ph == 5);
      write_reg(REG_DEAD, (ph == 6) ? 32'h3FFFF : $urandom_range(ph * 300));
      for (int n = 0; n < 48; n++) begin
        random_command();
        if (n == 20 && ph == 2) drain();
      end
      drain();
    end

    if (errors == 0) begin
      $display("swerve_inverse_kinematics_top: match");
    end else begin
      $display("swerve_inverse_kinematics_top: mismatch");
    end
    $finish;
  end
endmodule
